// ===== rtl/eadec_pkg.sv =====
// eadec_pkg: shared widths, register indexes, reset values and codes for the
// stereo adpcm decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eadec_pkg;

  localparam int SUB_BLOCK_SAMPLES = 28;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int PHASE_W  = 5;
  localparam int COEF_W   = 16;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // input word kind carried in tuser
  typedef enum logic {
    OP_CHUNK_START = 1'b0,
    OP_STREAM_BYTE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A_SEL0 = 3'd0,
    REG_COEF_A_SEL1 = 3'd1,
    REG_COEF_A_SEL2 = 3'd2,
    REG_COEF_A_SEL3 = 3'd3,
    REG_COEF_B_SEL0 = 3'd4,
    REG_COEF_B_SEL1 = 3'd5,
    REG_COEF_B_SEL2 = 3'd6,
    REG_COEF_B_SEL3 = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_0 = 2'd0,
    SEL_1 = 2'd1,
    SEL_2 = 2'd2,
    SEL_3 = 2'd3
  } sel_e;

  // sub-block phase: selector byte, shift byte, then data bytes
  localparam logic [PHASE_W-1:0] PHASE_SEL   = 5'd0;
  localparam logic [PHASE_W-1:0] PHASE_SHIFT = 5'd1;
  localparam logic [PHASE_W-1:0] PHASE_DATA0 = 5'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] a3;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] b3;
  } coef_t;

  localparam coef_t COEF_RESET = '{
    a0: 16'sd0,   a1: 16'sd240,  a2: 16'sd460,   a3: 16'sd392,
    b0: 16'sd0,   b1: 16'sd0,    b2: -16'sd208,  b3: -16'sd220
  };

endpackage

`default_nettype wire

// ===== rtl/ea_adpcm_stereo_decoder.sv =====
// Stereo adpcm decoder, one coded byte per word.
// Depends on eadec_pkg for widths, register indexes and coefficient defaults.
//
// Usage:
//   s_axis carries input words. tuser is the kind: 0 starts a chunk and loads
//   the four history samples and the sample count from tdata, 1 is a coded
//   stream byte (selector byte, shift byte, then data bytes per sub-block).
//   m_axis carries one stereo sample per data byte; tlast marks the final
//   sample of the chunk, tuser flags a selector above 3.
//   cfg_we_i/cfg_index_i/cfg_data_i write the eight predictor coefficients;
//   write them only while no word is in flight.
// Timing:
//   one word per cycle sustained while m_axis_tready stays high. A byte
//   accepted on s_axis first sits in the input register, then the decode
//   (two 16x16 multiply-adds per channel, round, clip) runs into the output
//   register. The history update closes in that same step, so bytes follow
//   each other with no gap.
// Reset:
//   clears history, count and phase; coefficients return to their defaults.
//   With the count at zero, stream bytes are dropped until a chunk start.
// Stall:
//   when m_axis_tready is low the result holds, the input register takes one
//   more word if it is empty, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module ea_adpcm_stereo_decoder
  import eadec_pkg::*;
#(
  parameter int SubBlockSamples = SUB_BLOCK_SAMPLES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // stream_byte, init_cur_left, init_prev_left, init_cur_right,
  // init_prev_right, chunk_samples (from bit 0 up)
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // left_sample, right_sample (from bit 0 up)
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  // bad_selector
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [COEF_W-1:0]     cfg_data_i
);

  localparam logic [PHASE_W-1:0] PhaseEnd = PHASE_W'(SubBlockSamples + 2);

  // input register
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                 in_user_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  out_bad_q, out_bad_d;

  coef_t coef_q;

  logic signed [SAMPLE_W-1:0] cur_l_q, cur_l_d, prev_l_q, prev_l_d;
  logic signed [SAMPLE_W-1:0] cur_r_q, cur_r_d, prev_r_q, prev_r_d;
  logic [3:0]                 sel_l_q, sel_l_d, sel_r_q, sel_r_d;
  // shift nibbles; the effective shift is nibble plus 8
  logic [3:0]                 shn_l_q, shn_l_d, shn_r_q, shn_r_d;
  logic [PHASE_W-1:0]         phase_q, phase_d, phase_inc;
  logic [COUNT_W-1:0]         count_q, count_d;

  logic out_free, proc;
  logic signed [SAMPLE_W-1:0] y_l, y_r;
  logic [7:0] in_byte;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign in_byte   = in_data_q[7:0];
  assign phase_inc = phase_q + 5'd1;

  function automatic logic signed [SAMPLE_W-1:0] decode_ch(
    input logic [3:0]                 code,
    input logic [3:0]                 sel,
    input logic [3:0]                 shn,
    input logic signed [SAMPLE_W-1:0] cur,
    input logic signed [SAMPLE_W-1:0] prev,
    input coef_t                      cf
  );
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [23:0]       delta;
    logic signed [31:0]       p1;
    logic signed [31:0]       p2;
    logic signed [33:0]       acc;
    logic signed [25:0]       y;
    logic signed [SAMPLE_W-1:0] res;
    c1 = '0;
    c2 = '0;
    if (sel[3:2] == 2'b00) begin
      case (sel_e'(sel[1:0]))
        SEL_0:   begin c1 = cf.a0; c2 = cf.b0; end
        SEL_1:   begin c1 = cf.a1; c2 = cf.b1; end
        SEL_2:   begin c1 = cf.a2; c2 = cf.b2; end
        default: begin c1 = cf.a3; c2 = cf.b3; end
      endcase
    end
    // code in the top nibble at 2^20 scale (2^28 scale shifted by 8), then shifted by the nibble
    delta = $signed({code, 20'b0}) >>> shn;
    p1    = cur * c1;
    p2    = prev * c2;
    acc   = 34'(delta) + 34'(p1) + 34'(p2) + 34'sd128;
    y     = acc[33:8];
    if (y > 26'sd32767) begin
      res = 16'sh7fff;
    end else if (y < -26'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = y[15:0];
    end
    return res;
  endfunction

  assign y_l = decode_ch(in_byte[7:4], sel_l_q, shn_l_q, cur_l_q, prev_l_q, coef_q);
  assign y_r = decode_ch(in_byte[3:0], sel_r_q, shn_r_q, cur_r_q, prev_r_q, coef_q);

  always_comb begin
    cur_l_d     = cur_l_q;
    prev_l_d    = prev_l_q;
    cur_r_d     = cur_r_q;
    prev_r_d    = prev_r_q;
    sel_l_d     = sel_l_q;
    sel_r_d     = sel_r_q;
    shn_l_d     = shn_l_q;
    shn_r_d     = shn_r_q;
    phase_d     = phase_q;
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_data_d  = {y_r, y_l};
    out_last_d  = (count_q == 24'd1);
    out_bad_d   = (sel_l_q[3:2] != 2'b00) || (sel_r_q[3:2] != 2'b00);
    if (op_e'(in_user_q) == OP_CHUNK_START) begin
      cur_l_d  = in_data_q[23:8];
      prev_l_d = in_data_q[39:24];
      cur_r_d  = in_data_q[55:40];
      prev_r_d = in_data_q[71:56];
      count_d  = in_data_q[95:72];
      phase_d  = PHASE_SEL;
    end else if (count_q != '0) begin
      case (phase_q)
        PHASE_SEL: begin
          sel_l_d = in_byte[7:4];
          sel_r_d = in_byte[3:0];
          phase_d = PHASE_SHIFT;
        end
        PHASE_SHIFT: begin
          shn_l_d = in_byte[7:4];
          shn_r_d = in_byte[3:0];
          phase_d = PHASE_DATA0;
        end
        default: begin
          prev_l_d    = cur_l_q;
          cur_l_d     = y_l;
          prev_r_d    = cur_r_q;
          cur_r_d     = y_r;
          count_d     = count_q - 24'd1;
          phase_d     = (phase_inc >= PhaseEnd) ? PHASE_SEL : phase_inc;
          out_valid_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_l_q  <= '0;
      prev_l_q <= '0;
      cur_r_q  <= '0;
      prev_r_q <= '0;
      sel_l_q  <= '0;
      sel_r_q  <= '0;
      shn_l_q  <= '0;
      shn_r_q  <= '0;
      phase_q  <= PHASE_SEL;
      count_q  <= '0;
    end else if (proc) begin
      cur_l_q  <= cur_l_d;
      prev_l_q <= prev_l_d;
      cur_r_q  <= cur_r_d;
      prev_r_q <= prev_r_d;
      sel_l_q  <= sel_l_d;
      sel_r_q  <= sel_r_d;
      shn_l_q  <= shn_l_d;
      shn_r_q  <= shn_r_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && out_valid_d) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
      out_bad_q  <= out_bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_COEF_A_SEL0: coef_q.a0 <= cfg_data_i;
        REG_COEF_A_SEL1: coef_q.a1 <= cfg_data_i;
        REG_COEF_A_SEL2: coef_q.a2 <= cfg_data_i;
        REG_COEF_A_SEL3: coef_q.a3 <= cfg_data_i;
        REG_COEF_B_SEL0: coef_q.b0 <= cfg_data_i;
        REG_COEF_B_SEL1: coef_q.b1 <= cfg_data_i;
        REG_COEF_B_SEL2: coef_q.b2 <= cfg_data_i;
        REG_COEF_B_SEL3: coef_q.b3 <= cfg_data_i;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

`ifndef ASSERT_OFF
  // a pending last sample means the chunk count has run out
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (count_q == '0))
    else $error("last sample pending with chunk count nonzero");

  // a new result comes only from a word held in the input register
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without a buffered input word");

  // a selector byte is always followed by the shift phase
  a_hdr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_user_q && count_q != '0 && phase_q == PHASE_SEL)
      |=> (phase_q == PHASE_SHIFT))
    else $error("selector byte did not advance to shift phase");

  // phase stays inside the sub-block
  a_phase_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (phase_q < PhaseEnd))
    else $error("sub-block phase out of range");
`endif

endmodule

`default_nettype wire

// ===== dv/ea_adpcm_stereo_decoder_test.sv =====
// Self-checking bench for the stereo adpcm decoder: streams chunk starts and
// coded bytes, predicts every stereo sample and compares them in order.
// Depends on eadec_pkg and the ea_adpcm_stereo_decoder rtl.
`timescale 1ns / 1ps

module ea_adpcm_stereo_decoder_test;
  import eadec_pkg::*;

  typedef struct {
    op_e                      op;
    logic [7:0]               code_byte;
    logic signed [SAMPLE_W-1:0] cur_l;
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] cur_r;
    logic signed [SAMPLE_W-1:0] prev_r;
    logic [COUNT_W-1:0]       count;
  } in_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
    logic                       bad;
  } stereo_sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  // stream_byte, init_cur_left, init_prev_left, init_cur_right,
  // init_prev_right, chunk_samples (from bit 0 up)
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // op
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // left_sample, right_sample (from bit 0 up)
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  // bad_selector
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [COEF_W-1:0]     cfg_data_i = '0;

  // predictor copy of the decoder state
  logic signed [COEF_W-1:0]   coef_regs [8];
  logic signed [SAMPLE_W-1:0] cur_l, prev_l, cur_r, prev_r;
  logic [3:0]                 sel_l, sel_r;
  logic [4:0]                 shift_l, shift_r;
  logic [PHASE_W-1:0]         dec_phase;
  logic [COUNT_W-1:0]         dec_remaining;

  stereo_sample_t expected_samples [$];
  int  mismatches = 0;
  logic steady = 1'b0;

  ea_adpcm_stereo_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // coef_t packs a0 in the top bits, so register i sits at flat[7-i]
  function automatic logic [COEF_W-1:0] coef_word(input coef_t c, input int idx);
    logic [7:0][COEF_W-1:0] flat;
    flat = c;
    return flat[7-idx];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_sample(
      input logic [3:0] code, input logic [3:0] sel, input logic [4:0] shift,
      input logic signed [SAMPLE_W-1:0] cur, input logic signed [SAMPLE_W-1:0] prev);
    longint n, c1, c2, acc;
    n  = code[3] ? longint'(code) - 16 : longint'(code);
    c1 = 0;
    c2 = 0;
    if (sel <= SEL_3) begin
      c1 = coef_regs[REG_COEF_A_SEL0 + sel];
      c2 = coef_regs[REG_COEF_B_SEL0 + sel];
    end
    // full-width sum, floor shift, then clip
    acc = n * (longint'(1) << (28 - shift)) + longint'(cur) * c1
          + longint'(prev) * c2 + 128;
    acc = acc >>> 8;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic decode_word(input in_word_t w);
    stereo_sample_t s;
    if (w.op == OP_CHUNK_START) begin
      cur_l = w.cur_l;
      prev_l = w.prev_l;
      cur_r = w.cur_r;
      prev_r = w.prev_r;
      dec_remaining = w.count;
      dec_phase = PHASE_SEL;
    end else if (dec_remaining != 0) begin
      if (dec_phase == PHASE_SEL) begin
        sel_l = w.code_byte[7:4];
        sel_r = w.code_byte[3:0];
        dec_phase = PHASE_SHIFT;
      end else if (dec_phase == PHASE_SHIFT) begin
        shift_l = {1'b0, w.code_byte[7:4]} + 5'd8;
        shift_r = {1'b0, w.code_byte[3:0]} + 5'd8;
        dec_phase = PHASE_DATA0;
      end else begin
        s.left = predict_sample(w.code_byte[7:4], sel_l, shift_l, cur_l, prev_l);
        s.right = predict_sample(w.code_byte[3:0], sel_r, shift_r, cur_r, prev_r);
        prev_l = cur_l;
        cur_l = s.left;
        prev_r = cur_r;
        cur_r = s.right;
        dec_remaining--;
        dec_phase++;
        if (dec_phase - PHASE_DATA0 >= SUB_BLOCK_SAMPLES) dec_phase = PHASE_SEL;
        s.last = (dec_remaining == 0);
        s.bad = (sel_l > SEL_3) || (sel_r > SEL_3);
        expected_samples.push_back(s);
      end
    end
  endtask

  function automatic in_word_t chunk_word(input int cl, input int pl, input int cr,
                                          input int pr, input int unsigned count);
    in_word_t w;
    w.op = OP_CHUNK_START;
    w.code_byte = 8'($urandom);
    w.cur_l = 16'(cl);
    w.prev_l = 16'(pl);
    w.cur_r = 16'(cr);
    w.prev_r = 16'(pr);
    w.count = 24'(count);
    return w;
  endfunction

  function automatic in_word_t byte_word(input logic [7:0] b);
    in_word_t w;
    w.op = OP_STREAM_BYTE;
    w.code_byte = b;
    w.cur_l = 16'($urandom);
    w.prev_l = 16'($urandom);
    w.cur_r = 16'($urandom);
    w.prev_r = 16'($urandom);
    w.count = 24'($urandom);
    return w;
  endfunction

  // entered and left just after a rising edge
  task automatic send_word(input in_word_t w);
    while (!steady && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= w.op;
    s_axis_tdata <= {w.count, w.prev_r, w.cur_r, w.prev_l, w.cur_l, w.code_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_word(w);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  // drained plus the pipeline depth, so header words are done too
  task automatic settle();
    hold_until_drained();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_coefs(input coef_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i <= coef_word(c, i);
      @(posedge clk_i);
      coef_regs[i] = coef_word(c, i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_header_and_chunk_cases();
    send_word(chunk_word(32767, -32768, -32768, 32767, 3));
    send_word(byte_word(8'h12));
    send_word(byte_word(8'h0F));
    send_word(byte_word(8'h7F));
    send_word(byte_word(8'h80));
    send_word(byte_word(8'hF7));
    // chunk finished, dropped
    send_word(byte_word(8'hFF));
    // empty chunk drops every byte
    send_word(chunk_word(0, 0, 0, 0, 0));
    send_word(byte_word(8'hAB));
    // unknown selector on the left
    send_word(chunk_word(-1, 1, 100, -100, 2));
    send_word(byte_word(8'hF3));
    send_word(byte_word(8'hF0));
    send_word(byte_word(8'h88));
    send_word(byte_word(8'h77));
    send_word(chunk_word(0, 0, 0, 0, 24'hFFFFFF));
    send_word(byte_word(8'h30));
    send_word(byte_word(8'hA5));
    send_word(byte_word(8'h19));
    send_word(byte_word(8'hE6));
  endtask

  task automatic test_wide_sums();
    settle();
    load_coefs('{a0: -16'sd32768, a1: 16'sd32767, a2: -16'sd32768, a3: 16'sd32767,
                 b0: -16'sd32768, b1: 16'sd32767, b2: 16'sd32767, b3: -16'sd32768});
    send_word(chunk_word(-32768, -32768, 32767, 32767, 2));
    send_word(byte_word(8'h01));
    send_word(byte_word(8'hF0));
    send_word(byte_word(8'h87));
    send_word(byte_word(8'h78));
  endtask

  // mostly well-formed sub-blocks, with early restarts and stray bytes
  task automatic random_stream(input int n_items);
    int sent;
    int unsigned pick;
    int unsigned count;
    logic [3:0] sel_hi, sel_lo;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (dec_remaining == 0 || pick < 2) begin
        if (dec_remaining == 0 && pick > 90) send_word(byte_word(8'($urandom)));
        count = $urandom_range(99);
        if (count < 10) count = 0;
        else if (count < 20) count = $urandom_range(120, 61);
        else count = $urandom_range(60, 1);
        send_word(chunk_word($urandom, $urandom, $urandom, $urandom, count));
      end else if (dec_phase == PHASE_SEL) begin
        sel_hi = ($urandom_range(99) < 90) ? 4'($urandom_range(3))
                                           : 4'($urandom_range(15, 4));
        sel_lo = ($urandom_range(99) < 90) ? 4'($urandom_range(3))
                                           : 4'($urandom_range(15, 4));
        send_word(byte_word({sel_hi, sel_lo}));
      end else begin
        send_word(byte_word(8'($urandom)));
      end
      sent++;
    end
  endtask

  task automatic test_random_coefs(input int n_items);
    settle();
    load_coefs(coef_t'({$urandom, $urandom, $urandom, $urandom}));
    random_stream(n_items);
  endtask

  task automatic test_extreme_coefs(input int n_items);
    settle();
    load_coefs('{a0: 16'sd32767, a1: -16'sd32768, a2: 16'sd32767, a3: -16'sd32768,
                 b0: -16'sd32768, b1: 16'sd32767, b2: -16'sd32768, b3: 16'sd32767});
    random_stream(n_items);
  endtask

  task automatic test_default_coefs_with_pause(input int n_items);
    settle();
    load_coefs(COEF_RESET);
    steady <= 1'b1;
    random_stream(n_items / 2);
    steady <= 1'b0;
    hold_until_drained();
    random_stream(n_items / 2);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    stereo_sample_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %h last %b bad %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        compare_field("left", want.left, m_axis_tdata[15:0]);
        compare_field("right", want.right, m_axis_tdata[31:16]);
        compare_field("last", 16'(want.last), 16'(m_axis_tlast));
        compare_field("bad_selector", 16'(want.bad), 16'(m_axis_tuser));
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 6);
  end

  initial begin
    for (int i = 0; i < 8; i++) coef_regs[i] = coef_word(COEF_RESET, i);
    cur_l = '0;
    prev_l = '0;
    cur_r = '0;
    prev_r = '0;
    sel_l = '0;
    sel_r = '0;
    shift_l = 5'd8;
    shift_r = 5'd8;
    dec_phase = PHASE_SEL;
    dec_remaining = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_and_chunk_cases();
    test_wide_sums();
    test_random_coefs(450);
    test_extreme_coefs(250);
    test_default_coefs_with_pause(700);
    test_random_coefs(300);
    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("ea_adpcm_stereo_decoder_test OK");
    end else begin
      $display("ea_adpcm_stereo_decoder_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ea_adpcm_stereo_decoder_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/eadec_pkg.sv
rtl/ea_adpcm_stereo_decoder.sv
dv/ea_adpcm_stereo_decoder_test.sv
